// File: sv/tthd_pkg.sv
// ============================================================================
// tthd_pkg - shared types and constants for the touch tap/hold detector
// Register indexes, reset values, field widths, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
package tthd_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int TIME_W    = 32;
    localparam int DEB_W     = 16;
    localparam int WIN_W     = 16;
    localparam int RCNT_W    = 4;
    localparam int S_TDATA_W = 40;   // now_ms (32) + pin_level (1), padded
    localparam int M_TDATA_W = 40;   // 5 flags + held_time_ms (32), padded
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [TIME_W-1:0] HOLD_RST  = 32'd1000;
    localparam logic [DEB_W-1:0]  DEB_RST   = 16'd50;
    localparam logic [WIN_W-1:0]  WIN_RST   = 16'd1500;
    localparam logic [RCNT_W-1:0] RCNT_RST  = 4'd3;

    typedef enum logic [2:0] {
        REG_HOLD_THRESHOLD = 3'd0,
        REG_DEBOUNCE       = 3'd1,
        REG_ACTIVE_LOW     = 3'd2,
        REG_RAPID_WINDOW   = 3'd3,
        REG_RAPID_COUNT    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        logic accept;     // take the sample and update debounce state
        logic scan_en;    // check one tap-history entry
        logic load_out;   // move the finished result into the output register
    } cmd_t;

    typedef struct packed {
        logic tap_now;    // the sample being accepted produces a tap
        logic scan_last;  // the entry being checked is the last one
        logic out_free;   // the output register can take a result
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0] hold_threshold_ms;
        logic [DEB_W-1:0]  debounce_ms;
        logic              active_low;
        logic [WIN_W-1:0]  rapid_window_ms;
        logic [RCNT_W-1:0] rapid_tap_count;
    } cfg_t;

endpackage

// File: sv/touch_tap_hold_detector_unit.sv
// ============================================================================
// touch_tap_hold_detector_unit - debounced touch pin with tap/hold events
// Debounces timestamped pin samples, reports hold, release, tap and
// rapid-tap pulses and the held time, one result per sample.
// ============================================================================
//
//  channel  | ports          | content
//  ---------+----------------+---------------------------------------------
//  input    | s_tvalid/tready| s_tdata: now_ms, pin_level
//  result   | m_tvalid/tready| m_tdata: flags, held_time_ms
//  config   | APB psel..     | five registers at byte address 4*index
//
//  A sample without a tap goes from ST_IDLE through ST_EMIT to the output
//  register; a sample that records a tap passes through ST_SCAN as well,
//  the history scan that checks one ring entry per cycle.
//  A new sample is taken while the previous result still waits on m_tready;
//  a stalled output holds the controller before the next output load.
//  Synchronous active-low reset empties the ring and restores register
//  defaults at once.
//
module touch_tap_hold_detector_unit #(
    parameter int HISTORY_DEPTH = tthd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input request
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tthd_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] now_ms, [32] pin_level
    // result request
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] touched, [1] tap_event, [2] hold_event, [3] release_event,
    // [4] rapid_tap_event, [36:5] held_time_ms
    output logic [tthd_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tthd_pkg::PADDR_W-1:0]   paddr,
    input  logic [tthd_pkg::PDATA_W-1:0]   pwdata,
    output logic [tthd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    tthd_pkg::cfg_t    cfg_reg;
    tthd_pkg::cmd_t    cmd;
    tthd_pkg::status_t status;
    tthd_pkg::reg_idx_t cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // decode the register index from the word address
    assign cfg_idx = tthd_pkg::reg_idx_t'(paddr[4:2]);

    // write the addressed register; ignore addresses beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_threshold_ms <= tthd_pkg::HOLD_RST;
            cfg_reg.debounce_ms       <= tthd_pkg::DEB_RST;
            cfg_reg.active_low        <= 1'b0;
            cfg_reg.rapid_window_ms   <= tthd_pkg::WIN_RST;
            cfg_reg.rapid_tap_count   <= tthd_pkg::RCNT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tthd_pkg::REG_HOLD_THRESHOLD: cfg_reg.hold_threshold_ms <= pwdata;
                tthd_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ms <= pwdata[tthd_pkg::DEB_W-1:0];
                tthd_pkg::REG_ACTIVE_LOW:     cfg_reg.active_low <= pwdata[0];
                tthd_pkg::REG_RAPID_WINDOW:
                    cfg_reg.rapid_window_ms <= pwdata[tthd_pkg::WIN_W-1:0];
                tthd_pkg::REG_RAPID_COUNT:
                    cfg_reg.rapid_tap_count <= pwdata[tthd_pkg::RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // return the addressed register, zero-extended; zero outside the list or when paddr[1:0] is not zero
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (cfg_idx)
                tthd_pkg::REG_HOLD_THRESHOLD: prdata = cfg_reg.hold_threshold_ms;
                tthd_pkg::REG_DEBOUNCE:
                    prdata = {{(tthd_pkg::PDATA_W-tthd_pkg::DEB_W){1'b0}},
                              cfg_reg.debounce_ms};
                tthd_pkg::REG_ACTIVE_LOW:
                    prdata = {{(tthd_pkg::PDATA_W-1){1'b0}}, cfg_reg.active_low};
                tthd_pkg::REG_RAPID_WINDOW:
                    prdata = {{(tthd_pkg::PDATA_W-tthd_pkg::WIN_W){1'b0}},
                              cfg_reg.rapid_window_ms};
                tthd_pkg::REG_RAPID_COUNT:
                    prdata = {{(tthd_pkg::PDATA_W-tthd_pkg::RCNT_W){1'b0}},
                              cfg_reg.rapid_tap_count};
                default: prdata = '0;
            endcase
        end
    end

    tthd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tthd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// File: sv/tthd_ctrl.sv
// ============================================================================
// tthd_ctrl - sequencing controller
// Accepts a sample, runs the tap-history scan when a tap occurred, then
// hands the result to the output register.
// ============================================================================
module tthd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tthd_pkg::status_t status,
    output tthd_pkg::cmd_t    cmd
);

    tthd_pkg::state_t state_reg;
    tthd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tthd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            tthd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.tap_now ? tthd_pkg::ST_SCAN : tthd_pkg::ST_EMIT;
                end
            end
            tthd_pkg::ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_last) begin
                    state_next = tthd_pkg::ST_EMIT;
                end
            end
            tthd_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = tthd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tthd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/tthd_datapath.sv
// ============================================================================
// tthd_datapath - debounce state, tap history ring and output register
// Holds the debounce/hold state, records taps in a ring of timestamps,
// counts recent taps one entry a cycle and holds the result for the stream.
// ============================================================================
module tthd_datapath #(
    parameter int HISTORY_DEPTH = tthd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tthd_pkg::cfg_t                   cfg,
    input  logic [tthd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tthd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  tthd_pkg::cmd_t                   cmd,
    output tthd_pkg::status_t                status
);

    localparam int TW    = tthd_pkg::TIME_W;
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (CNT_W > tthd_pkg::RCNT_W) ? CNT_W : tthd_pkg::RCNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    // debounce and hold state
    logic          last_raw_reg, last_raw_next;
    logic          stable_reg, stable_next;
    logic          hold_done_reg, hold_done_next;
    logic [TW-1:0] change_time_reg, change_time_next;
    logic [TW-1:0] press_time_reg, press_time_next;

    // tap history ring
    logic [TW-1:0]            tap_times [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] tap_valid_reg;
    logic [IDX_W-1:0]         tap_slot_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic [CNT_W-1:0]         count_reg;

    // pending result
    logic          res_touched_reg, res_tap_reg, res_hold_reg, res_rel_reg;
    logic [TW-1:0] res_held_reg;
    logic [TW-1:0] now_reg;

    logic                          m_tvalid_reg;
    logic [tthd_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [TW-1:0] now;
    logic          raw;
    logic          hold_ev, rel_ev, tap_ev;
    logic [TW-1:0] held_calc;
    logic [TW-1:0] age;
    logic          in_window;
    logic          rapid;

    assign now = s_tdata[TW-1:0];
    assign raw = s_tdata[TW] ^ cfg.active_low;

    // one debounce step
    always_comb begin
        last_raw_next    = last_raw_reg;
        stable_next      = stable_reg;
        hold_done_next   = hold_done_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        hold_ev          = 1'b0;
        rel_ev           = 1'b0;
        tap_ev           = 1'b0;
        priority if (raw != last_raw_reg) begin
            last_raw_next    = raw;
            change_time_next = now;
        end else if (raw == stable_reg) begin
            if (stable_reg && !hold_done_reg &&
                ((now - press_time_reg) >= cfg.hold_threshold_ms)) begin
                hold_done_next = 1'b1;
                hold_ev        = 1'b1;
            end
        end else if ((now - change_time_reg) >= {{(TW-tthd_pkg::DEB_W){1'b0}},
                                                 cfg.debounce_ms}) begin
            stable_next = raw;
            if (raw) begin
                press_time_next = now;
                hold_done_next  = 1'b0;
            end else begin
                rel_ev = 1'b1;
                tap_ev = !hold_done_reg;
            end
        end
        held_calc = stable_next ? (now - press_time_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            hold_done_reg   <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end else if (cmd.accept) begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            hold_done_reg   <= hold_done_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_touched_reg <= stable_next;
            res_tap_reg     <= tap_ev;
            res_hold_reg    <= hold_ev;
            res_rel_reg     <= rel_ev;
            res_held_reg    <= held_calc;
            now_reg         <= now;
        end
    end

    // ring write on a tap
    always_ff @(posedge aclk) begin
        if (cmd.accept && tap_ev) begin
            tap_times[tap_slot_reg] <= now;
        end
    end

    assign age       = now_reg - tap_times[scan_idx_reg];
    assign in_window = tap_valid_reg[scan_idx_reg] &&
                       (age <= {{(TW-tthd_pkg::WIN_W){1'b0}}, cfg.rapid_window_ms});
    assign rapid     = res_tap_reg &&
                       (CMP_W'(count_reg) >= CMP_W'(cfg.rapid_tap_count));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_valid_reg <= '0;
            tap_slot_reg  <= '0;
            scan_idx_reg  <= '0;
            count_reg     <= '0;
        end else begin
            if (cmd.accept) begin
                scan_idx_reg <= '0;
                count_reg    <= '0;
                if (tap_ev) begin
                    tap_valid_reg[tap_slot_reg] <= 1'b1;
                    tap_slot_reg <= (tap_slot_reg == LAST_IDX) ? '0 : tap_slot_reg + 1'b1;
                end
            end
            if (cmd.scan_en) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (in_window) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.load_out && rapid) begin
                tap_valid_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {3'b000, res_held_reg, rapid, res_rel_reg, res_hold_reg,
                            res_tap_reg, res_touched_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.tap_now   = tap_ev;
    assign status.scan_last = (scan_idx_reg == LAST_IDX);
    assign status.out_free  = !m_tvalid_reg || m_tready;

endmodule
